// ----- design/smbs_pkg.sv -----
`default_nettype none

package smbs_pkg;

    // Byte and bank geometry
    localparam int BITS_PER_WORD = 8;
    localparam int WORD_W        = 32;
    localparam int BIT_W         = $clog2(BITS_PER_WORD);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Slot numbering inside one byte: open, 2 per bit, gap, close
    localparam int SLOT_COUNT = 2 * BITS_PER_WORD + 3;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);

    localparam logic [SLOT_W-1:0] SLOT_OPEN      = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_FIRST_BIT = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_GAP       = SLOT_W'(2 * BITS_PER_WORD + 1);
    localparam logic [SLOT_W-1:0] SLOT_CLOSE     = SLOT_W'(2 * BITS_PER_WORD + 2);

    // Hold codes
    localparam logic [1:0] HOLD_UNTIL_NEXT = 2'd0;
    localparam logic [1:0] HOLD_HALF       = 2'd1;
    localparam logic [1:0] HOLD_FULL       = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_POLARITY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_PHASE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD_CYCLES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_PIN_MASK     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_OUT_PIN_MASK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_PIN_MASK    = 3'd5;

    // Configuration reset values
    localparam logic [WORD_W-1:0] RESET_CLOCK_PIN_MASK    = 32'h0000_0001;
    localparam logic [WORD_W-1:0] RESET_DATA_OUT_PIN_MASK = 32'h0000_0002;
    localparam logic [WORD_W-1:0] RESET_SELECT_PIN_MASK   = 32'h0000_0008;

    // One classified byte, as queued from front to back
    typedef struct packed {
        logic [BITS_PER_WORD-1:0] data_byte;
        logic                     last_byte;
        logic                     open_first;
    } t_cmd;

    // Live configuration seen by the sequencer
    typedef struct packed {
        logic              clock_polarity;
        logic              clock_phase;
        logic [WORD_W-1:0] clock_pin_mask;
        logic [WORD_W-1:0] data_out_pin_mask;
        logic [WORD_W-1:0] select_pin_mask;
    } t_cfg;

    // One pin-state slot
    typedef struct packed {
        logic              clock_level;
        logic              data_level;
        logic              select_level;
        logic [WORD_W-1:0] gpio_word;
        logic [1:0]        hold_halves;
        logic              last_of_run;
    } t_slot;

    // Bank word while selected: select bit low, clock/data bits low when level is low
    function automatic logic [WORD_W-1:0] active_word(t_cfg cfg, logic clk, logic dat);
        logic [WORD_W-1:0] w;
        w = ~cfg.select_pin_mask;
        if (!clk) begin
            w = w & ~cfg.clock_pin_mask;
        end
        if (!dat) begin
            w = w & ~cfg.data_out_pin_mask;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- design/smbs_front.sv -----
`default_nettype none

module smbs_front (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_push,
    input  wire [smbs_pkg::BITS_PER_WORD-1:0]      i_data_byte,
    input  wire                                    i_last_byte,
    input  wire                                    i_queue_full,
    output logic                                   o_full,
    output logic                                   o_queue_push,
    output smbs_pkg::t_cmd                         o_queue_cmd
);

    logic r_frame_open;
    logic n_frame_open;
    logic accept;

    // Take a byte whenever the command queue has room
    assign o_full       = i_queue_full;
    assign accept       = i_push && !i_queue_full;
    assign o_queue_push = accept;

    // Classify: the first byte of a frame also drops select
    always_comb begin
        o_queue_cmd.data_byte  = i_data_byte;
        o_queue_cmd.last_byte  = i_last_byte;
        o_queue_cmd.open_first = !r_frame_open;
    end

    // Track frame state across transfers
    always_comb begin
        n_frame_open = r_frame_open;
        if (accept) begin
            n_frame_open = !i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
        end else begin
            r_frame_open <= n_frame_open;
        end
    end

endmodule

`default_nettype wire

// ----- design/smbs_queue.sv -----
`default_nettype none

module smbs_queue #(
    parameter int DEPTH = smbs_pkg::QUEUE_DEPTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_wr,
    input  wire smbs_pkg::t_cmd i_wdata,
    output logic                o_full,
    input  wire                 i_rd,
    output smbs_pkg::t_cmd      o_rdata,
    output logic                o_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    smbs_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr;
    logic             do_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;
    assign o_rdata = r_mem[r_rptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/smbs_back.sv -----
`default_nettype none

module smbs_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire smbs_pkg::t_cfg i_cfg,
    input  wire                 i_queue_valid,
    input  wire smbs_pkg::t_cmd i_queue_cmd,
    output logic                o_queue_pop,
    input  wire                 i_pop,
    output logic                o_empty,
    output smbs_pkg::t_slot     o_slot
);

    logic                          r_busy;
    smbs_pkg::t_cmd                r_cmd;
    logic [smbs_pkg::SLOT_W-1:0]   r_idx;
    smbs_pkg::t_slot               r_out;
    logic                          r_out_valid;

    smbs_pkg::t_slot               slot;
    logic                          slot_final;
    logic                          adv;
    logic                          load;
    logic [smbs_pkg::SLOT_W-1:0]   bit_slot;
    logic [smbs_pkg::BIT_W-1:0]    bit_sel;
    logic                          idle_clk;
    logic                          first_clk;
    logic                          bit_val;

    // Bit slots: offset from first bit slot, pair number picks the bit MSB first
    assign idle_clk  = i_cfg.clock_polarity;
    assign first_clk = i_cfg.clock_polarity ^ i_cfg.clock_phase;
    assign bit_slot  = r_idx - smbs_pkg::SLOT_FIRST_BIT;
    assign bit_sel   = smbs_pkg::BIT_W'(smbs_pkg::BITS_PER_WORD - 1) - bit_slot[smbs_pkg::BIT_W:1];
    assign bit_val   = r_cmd.data_byte[bit_sel];

    // Build the current slot
    always_comb begin
        slot.clock_level  = idle_clk;
        slot.data_level   = 1'b0;
        slot.select_level = 1'b0;
        slot.gpio_word    = smbs_pkg::active_word(i_cfg, idle_clk, 1'b0);
        slot.hold_halves  = smbs_pkg::HOLD_HALF;
        slot.last_of_run  = 1'b0;
        slot_final        = 1'b0;
        if (r_idx == smbs_pkg::SLOT_OPEN) begin
            slot.hold_halves = smbs_pkg::HOLD_HALF;
        end else if (r_idx == smbs_pkg::SLOT_GAP) begin
            slot.hold_halves = r_cmd.last_byte ? smbs_pkg::HOLD_FULL : smbs_pkg::HOLD_HALF;
            slot.last_of_run = !r_cmd.last_byte;
            slot_final       = !r_cmd.last_byte;
        end else if (r_idx == smbs_pkg::SLOT_CLOSE) begin
            slot.select_level = 1'b1;
            slot.gpio_word    = i_cfg.select_pin_mask |
                                (idle_clk ? i_cfg.clock_pin_mask : '0);
            slot.hold_halves  = smbs_pkg::HOLD_UNTIL_NEXT;
            slot.last_of_run  = 1'b1;
            slot_final        = 1'b1;
        end else begin
            slot.clock_level = first_clk ^ bit_slot[0];
            slot.data_level  = bit_val;
            slot.gpio_word   = smbs_pkg::active_word(i_cfg, first_clk ^ bit_slot[0], bit_val);
        end
    end

    // Emit a slot whenever the output register is free or being drained
    assign adv         = r_busy && (!r_out_valid || i_pop);
    assign load        = i_queue_valid && (!r_busy || (adv && slot_final));
    assign o_queue_pop = load;

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= 1'b1;
        end else if (adv && slot_final) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_queue_cmd;
            r_idx <= i_queue_cmd.open_first ? smbs_pkg::SLOT_OPEN : smbs_pkg::SLOT_FIRST_BIT;
        end else if (adv) begin
            r_idx <= r_idx + smbs_pkg::SLOT_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= slot;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_slot  = r_out;

endmodule

`default_nettype wire

// ----- design/spi_master_bit_sequencer_unit.sv -----
// Write-only SPI master sequencer. Each byte pushed in becomes a run of
// pin-state slots popped out one per cycle while pop stays high: a
// select-drop slot when the byte opens a frame, two half-period slots per
// bit (MSB first), one gap slot, and after a byte marked last a
// select-rise slot. That is 17 to 19 slots per byte. The sequencer emits
// slots into its output register and loads the next queued byte as it
// emits the last slot of the current one. A two-entry command queue sits
// between the byte intake and the sequencer, so bytes can be pushed while
// the current one is still being played out. Slot timing is left to the
// consumer through hold_halves; the half-period register is accepted on
// the configuration port but does not change any slot. Configuration
// should be written only while no byte is in flight.
`default_nettype none

module spi_master_bit_sequencer_unit #(
    parameter int QUEUE_DEPTH = smbs_pkg::QUEUE_DEPTH
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // byte intake
    input  wire                                  push,
    output logic                                 full,
    input  wire [smbs_pkg::BITS_PER_WORD-1:0]    i_data_byte,
    input  wire                                  i_last_byte,
    // slot output
    output logic                                 empty,
    input  wire                                  pop,
    output logic                                 o_clock_level,
    output logic                                 o_data_level,
    output logic                                 o_select_level,
    output logic [smbs_pkg::WORD_W-1:0]          o_gpio_word,
    output logic [1:0]                           o_hold_halves,
    output logic                                 o_last_of_run,
    // configuration
    input  wire                                  i_cfg_we,
    input  wire [smbs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [smbs_pkg::WORD_W-1:0]           i_cfg_data
);

    smbs_pkg::t_cfg  r_cfg;
    smbs_pkg::t_cmd  front_cmd;
    smbs_pkg::t_cmd  queue_cmd;
    smbs_pkg::t_slot slot;
    logic            front_push;
    logic            queue_full;
    logic            queue_valid;
    logic            queue_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clock_polarity    <= 1'b0;
            r_cfg.clock_phase       <= 1'b0;
            r_cfg.clock_pin_mask    <= smbs_pkg::RESET_CLOCK_PIN_MASK;
            r_cfg.data_out_pin_mask <= smbs_pkg::RESET_DATA_OUT_PIN_MASK;
            r_cfg.select_pin_mask   <= smbs_pkg::RESET_SELECT_PIN_MASK;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                smbs_pkg::CFG_CLOCK_POLARITY:    r_cfg.clock_polarity    <= i_cfg_data[0];
                smbs_pkg::CFG_CLOCK_PHASE:       r_cfg.clock_phase       <= i_cfg_data[0];
                smbs_pkg::CFG_CLOCK_PIN_MASK:    r_cfg.clock_pin_mask    <= i_cfg_data;
                smbs_pkg::CFG_DATA_OUT_PIN_MASK: r_cfg.data_out_pin_mask <= i_cfg_data;
                smbs_pkg::CFG_SELECT_PIN_MASK:   r_cfg.select_pin_mask   <= i_cfg_data;
                // half period is informational only; unknown indexes drop
                default: begin
                end
            endcase
        end
    end

    smbs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .i_queue_full (queue_full),
        .o_full       (full),
        .o_queue_push (front_push),
        .o_queue_cmd  (front_cmd)
    );

    smbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_push),
        .i_wdata (front_cmd),
        .o_full  (queue_full),
        .i_rd    (queue_pop),
        .o_rdata (queue_cmd),
        .o_valid (queue_valid)
    );

    smbs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_queue_valid (queue_valid),
        .i_queue_cmd   (queue_cmd),
        .o_queue_pop   (queue_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_slot        (slot)
    );

    assign o_clock_level  = slot.clock_level;
    assign o_data_level   = slot.data_level;
    assign o_select_level = slot.select_level;
    assign o_gpio_word    = slot.gpio_word;
    assign o_hold_halves  = slot.hold_halves;
    assign o_last_of_run  = slot.last_of_run;

endmodule

`default_nettype wire

// ----- design/smbs_checker.sv -----
`default_nettype none

module smbs_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          empty,
    input wire                          pop,
    input wire                          o_select_level,
    input wire [smbs_pkg::WORD_W-1:0]   o_gpio_word,
    input wire [1:0]                    o_hold_halves,
    input wire                          o_last_of_run
);

    // Nothing to pop right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result visible after reset");

    // A held result stays put until it is popped
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_gpio_word) && $stable(o_select_level)))
        else $error("stalled result changed");

    // Select rise is always the closing slot of a byte, held until the next frame
    a_close_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_select_level) |->
            (o_hold_halves == smbs_pkg::HOLD_UNTIL_NEXT && o_last_of_run))
        else $error("select rise slot malformed");

    // A full-period gap is followed by the select-rise slot
    a_gap_then_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_hold_halves == smbs_pkg::HOLD_FULL) |=>
            (empty || o_select_level))
        else $error("full gap not followed by select rise");

endmodule

bind spi_master_bit_sequencer_unit smbs_checker u_smbs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_select_level (o_select_level),
    .o_gpio_word    (o_gpio_word),
    .o_hold_halves  (o_hold_halves),
    .o_last_of_run  (o_last_of_run)
);

`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smbs_pkg::*;

    localparam int              CLK_HALF        = 5;
    localparam int              CYCLE_LIMIT     = 500000;
    localparam int              SETTLE_CYCLES   = 8;
    localparam int              RX_LONG_HOLD    = 400;
    localparam int              RANDOM_PHASES   = 8;
    localparam int              ITEMS_PER_PHASE = 25;
    localparam int              PRESSURE_PHASE  = 3;
    localparam int              MAX_REPORTS     = 60;
    localparam logic [15:0]     HALF_PERIOD_RESET = 16'd50;
    // indexes past the register list; writes to them are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Expected pin-state slots, worked out from each accepted byte
    class slot_scoreboard;
        logic              cpol;
        logic              cpha;
        logic [15:0]       half_cycles;
        logic [WORD_W-1:0] clk_mask;
        logic [WORD_W-1:0] dat_mask;
        logic [WORD_W-1:0] sel_mask;
        bit                frame_open;
        t_slot             slot_queue[$];
        int                errors;
        int                slots_checked;
        int                bytes_taken;
        int                frames_closed;

        function void power_on();
            cpol        = 1'b0;
            cpha        = 1'b0;
            half_cycles = HALF_PERIOD_RESET;
            clk_mask    = RESET_CLOCK_PIN_MASK;
            dat_mask    = RESET_DATA_OUT_PIN_MASK;
            sel_mask    = RESET_SELECT_PIN_MASK;
            frame_open  = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
            case (idx)
                CFG_CLOCK_POLARITY:     cpol        = val[0];
                CFG_CLOCK_PHASE:        cpha        = val[0];
                CFG_HALF_PERIOD_CYCLES: half_cycles = val[15:0];
                CFG_CLOCK_PIN_MASK:     clk_mask    = val;
                CFG_DATA_OUT_PIN_MASK:  dat_mask    = val;
                CFG_SELECT_PIN_MASK:    sel_mask    = val;
                default: ;
            endcase
        endfunction

        // bank word while select is asserted
        function logic [WORD_W-1:0] selected_word(logic clk, logic dat);
            logic [WORD_W-1:0] w;
            w = ~sel_mask;
            if (!clk) w &= ~clk_mask;
            if (!dat) w &= ~dat_mask;
            return w;
        endfunction

        function void add_slot(logic clk, logic dat, logic sel, logic [WORD_W-1:0] word,
                               logic [1:0] hold);
            t_slot s;
            s.clock_level  = clk;
            s.data_level   = dat;
            s.select_level = sel;
            s.gpio_word    = word;
            s.hold_halves  = hold;
            s.last_of_run  = 1'b0;
            slot_queue.push_back(s);
        endfunction

        function void note_byte(logic [BITS_PER_WORD-1:0] data, logic last);
            logic idle_clk;
            logic lead_clk;
            logic b;
            idle_clk = cpol;
            lead_clk = cpol ^ cpha;
            bytes_taken++;
            // drop select with the clock parked
            if (!frame_open) begin
                add_slot(idle_clk, 1'b0, 1'b0, selected_word(idle_clk, 1'b0), HOLD_HALF);
                frame_open = 1'b1;
            end
            // two half periods per bit, MSB first
            for (int j = BITS_PER_WORD - 1; j >= 0; j--) begin
                b = data[j];
                add_slot(lead_clk, b, 1'b0, selected_word(lead_clk, b), HOLD_HALF);
                add_slot(~lead_clk, b, 1'b0, selected_word(~lead_clk, b), HOLD_HALF);
            end
            // gap, then raise select when the frame closes
            if (last) begin
                add_slot(idle_clk, 1'b0, 1'b0, selected_word(idle_clk, 1'b0), HOLD_FULL);
                add_slot(idle_clk, 1'b0, 1'b1, sel_mask | (idle_clk ? clk_mask : '0),
                         HOLD_UNTIL_NEXT);
                frame_open = 1'b0;
                frames_closed++;
            end else begin
                add_slot(idle_clk, 1'b0, 1'b0, selected_word(idle_clk, 1'b0), HOLD_HALF);
            end
            slot_queue[$].last_of_run = 1'b1;
        endfunction

        function void compare_field(string field, logic [WORD_W-1:0] want,
                                    logic [WORD_W-1:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: slot %0d %s mismatch, expected %0h actual %0h",
                             $time, slots_checked, field, want, got);
            end
        endfunction

        function void check_slot(t_slot got);
            t_slot want;
            if (slot_queue.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected slot, expected none actual %0h", $time, got);
                return;
            end
            want = slot_queue.pop_front();
            compare_field("clock_level",  want.clock_level,  got.clock_level);
            compare_field("data_level",   want.data_level,   got.data_level);
            compare_field("select_level", want.select_level, got.select_level);
            compare_field("gpio_word",    want.gpio_word,    got.gpio_word);
            compare_field("hold_halves",  want.hold_halves,  got.hold_halves);
            compare_field("last_of_run",  want.last_of_run,  got.last_of_run);
            slots_checked++;
        endfunction

        function int pending();
            return slot_queue.size();
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     push;
    logic                     full;
    logic [BITS_PER_WORD-1:0] i_data_byte;
    logic                     i_last_byte;
    logic                     empty;
    logic                     pop;
    logic                     o_clock_level;
    logic                     o_data_level;
    logic                     o_select_level;
    logic [WORD_W-1:0]        o_gpio_word;
    logic [1:0]               o_hold_halves;
    logic                     o_last_of_run;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [WORD_W-1:0]        i_cfg_data;

    slot_scoreboard sb;
    bit             tx_idle;
    bit             rx_idle;
    bit             rx_hold_req;
    int             settings_used;
    int             cycle_count;

    spi_master_bit_sequencer_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .empty          (empty),
        .pop            (pop),
        .o_clock_level  (o_clock_level),
        .o_data_level   (o_data_level),
        .o_select_level (o_select_level),
        .o_gpio_word    (o_gpio_word),
        .o_hold_halves  (o_hold_halves),
        .o_last_of_run  (o_last_of_run),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog: end the run if it stalls
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECK FAILED");
        $finish;
    end

    // Slot drain: check each transfer, then draw the next stall
    initial begin : slot_drain
        t_slot got;
        int    rx_wait;
        pop     <= 1'b0;
        rx_wait = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                got.clock_level  = o_clock_level;
                got.data_level   = o_data_level;
                got.select_level = o_select_level;
                got.gpio_word    = o_gpio_word;
                got.hold_halves  = o_hold_halves;
                got.last_of_run  = o_last_of_run;
                sb.check_slot(got);
                rx_wait = rx_idle ? $urandom_range(0, 6) : 0;
            end
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_wait     = RX_LONG_HOLD;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Offer one byte after a random gap; hold until the transfer
    task automatic send_byte(input logic [BITS_PER_WORD-1:0] data, input logic last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= data;
        i_last_byte <= last;
        do @(posedge i_clk); while (full);
        sb.note_byte(data, last);
    endtask

    // Drop push and wait until every expected slot is out
    task automatic settle();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    // Write the whole register set, optionally poking the unused indexes too
    task automatic set_config(input logic pol, input logic pha, input logic [15:0] half,
                              input logic [WORD_W-1:0] cmask, input logic [WORD_W-1:0] dmask,
                              input logic [WORD_W-1:0] smask, input bit with_spare);
        cfg_put(CFG_CLOCK_POLARITY, {{(WORD_W-1){1'b1}}, pol});
        cfg_put(CFG_CLOCK_PHASE, {{(WORD_W-1){1'b1}}, pha});
        cfg_put(CFG_HALF_PERIOD_CYCLES, {16'hffff, half});
        cfg_put(CFG_CLOCK_PIN_MASK, cmask);
        cfg_put(CFG_DATA_OUT_PIN_MASK, dmask);
        cfg_put(CFG_SELECT_PIN_MASK, smask);
        if (with_spare) begin
            cfg_put(CFG_SPARE_LO, $urandom);
            cfg_put(CFG_SPARE_HI, $urandom);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic random_config();
        logic [15:0]       half;
        logic [WORD_W-1:0] cm;
        logic [WORD_W-1:0] dm;
        logic [WORD_W-1:0] sm;
        case ($urandom_range(0, 3))
            0:       half = 16'd1;
            1:       half = 16'hffff;
            default: half = 16'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 2))
            0: begin
                // distinct single pins
                cm = 32'd1 << $urandom_range(0, 9);
                dm = 32'd1 << $urandom_range(10, 20);
                sm = 32'd1 << $urandom_range(21, 31);
            end
            1: begin
                cm = $urandom;
                dm = $urandom;
                sm = $urandom;
            end
            default: begin
                // single pins that may collide
                cm = 32'd1 << $urandom_range(0, 3);
                dm = 32'd1 << $urandom_range(0, 3);
                sm = 32'd1 << $urandom_range(0, 3);
            end
        endcase
        set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), half, cm, dm, sm,
                   $urandom_range(0, 3) == 0);
    endtask

    // Reset, directed cases, then random phases
    initial begin : stimulus
        sb = new;
        sb.power_on();
        settings_used = 1;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        rx_hold_req   = 1'b0;
        i_rst_n       <= 1'b0;
        push          <= 1'b0;
        i_data_byte   <= '0;
        i_last_byte   <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: one-byte frame, then a three-byte frame
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        settle();

        // remaining clock modes; frame left open across the writes
        set_config(1'b1, 1'b0, 16'd1, 32'h0000_0004, 32'h0000_0040, 32'h0000_0400, 1'b0);
        send_byte(8'ha5, 1'b0);
        settle();
        set_config(1'b0, 1'b1, 16'd2, 32'h0000_0100, 32'h0001_0000, 32'h8000_0000, 1'b0);
        send_byte(8'h5a, 1'b0);
        settle();
        set_config(1'b1, 1'b1, 16'd3, 32'h0000_0001, 32'h0000_0002, 32'h0000_0008, 1'b0);
        send_byte(8'h3c, 1'b1);
        send_byte(8'hc3, 1'b1);
        settle();

        // zero masks and zero half period
        set_config(1'b0, 1'b0, 16'd0, '0, '0, '0, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
        settle();

        // all pins on one mask, longest half period
        set_config(1'b1, 1'b0, 16'hffff, '1, '1, '1, 1'b1);
        send_byte(8'h81, 1'b1);
        send_byte(8'h7e, 1'b1);
        settle();

        // clock and data sharing a pin
        set_config(1'b0, 1'b1, 16'd2, 32'h0000_0010, 32'h0000_0010, 32'h8000_0000, 1'b0);
        send_byte(8'h96, 1'b0);
        send_byte(8'h69, 1'b1);
        settle();

        // random phases, one with a long receiver hold-off
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_config();
            tx_idle = (ph == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            rx_idle = (ph == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (ph == PRESSURE_PHASE) begin
                tx_idle     = 1'b0;
                rx_hold_req = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_byte(BITS_PER_WORD'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            settle();
        end

        // close any open frame so the run ends with select high
        if (sb.frame_open) begin
            send_byte(BITS_PER_WORD'($urandom_range(0, 255)), 1'b1);
            settle();
        end

        $display("run covered %0d bytes in %0d closed frames, %0d slots checked",
                 sb.bytes_taken, sb.frames_closed, sb.slots_checked);
        $display("across %0d register settings, all four clock modes, %0d mismatches",
                 settings_used, sb.errors);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- spi_master_bit_sequencer_unit.f -----
design/smbs_pkg.sv
design/smbs_front.sv
design/smbs_queue.sv
design/smbs_back.sv
design/spi_master_bit_sequencer_unit.sv
design/smbs_checker.sv
bench/testbench.sv
